// File: rtl/core/tcf_pkg.sv
// Shared types and constants of the transport connection engine.
`timescale 1ns / 1ps

package tcf_pkg;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0]  RESEND_RESET  = 8'd3;
    localparam logic [7:0]  CTRL_SEG_LEN  = 8'h01;

    localparam logic [3:0] SEG_CONNECT = 4'd0;
    localparam logic [3:0] SEG_ACCEPT  = 4'd1;
    localparam logic [3:0] SEG_SEND    = 4'd2;
    localparam logic [3:0] SEG_ACK     = 4'd3;
    localparam logic [3:0] SEG_NACK    = 4'd4;
    localparam logic [3:0] SEG_CLOSE   = 4'd5;

    typedef enum logic [1:0] {
        CFG_NET_ID     = 2'd0,
        CFG_OWN_ADDR   = 2'd1,
        CFG_TIMEOUT    = 2'd2,
        CFG_RESEND_LIM = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_OPEN = 2'd1,
        ST_DATA = 2'd2,
        ST_FAIL = 2'd3
    } t_conn_state;

    typedef enum logic [1:0] {
        ROLE_NONE   = 2'd0,
        ROLE_CLIENT = 2'd1,
        ROLE_HOST   = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_POLL = 2'd1,
        OP_RX   = 2'd2,
        OP_SENT = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        SK_NONE   = 2'd0,
        SK_NEW    = 2'd1,
        SK_RESEND = 2'd2
    } t_send_kind;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_ADDR     = 3'd1,
        STS_NET_ID   = 3'd2,
        STS_PORT     = 3'd3,
        STS_CHECKSUM = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  net_id;
        logic [7:0]  own_address;
        logic [15:0] timeout_ticks;
        logic [7:0]  resend_limit;
    } t_cfg;

    typedef struct packed {
        logic [3:0] seg_type;
        logic [3:0] encryption;
        logic [7:0] port;
        logic [7:0] address;
        logic [7:0] length;
        logic       from_app;
    } t_segment;

    typedef struct packed {
        t_conn_state state;
        t_role       role;
        logic        tx_busy;
        logic [7:0]  resends_left;
        logic [15:0] timer_count;
        t_segment    held;
    } t_ctx;

    typedef struct packed {
        t_opcode    opcode;
        logic       app_tx_pending;
        logic [7:0] app_tx_port;
        logic [7:0] app_tx_address;
        logic [3:0] app_encryption;
        logic [7:0] app_tx_length;
        logic [7:0] rx_address;
        logic [7:0] rx_net_id;
        logic [7:0] rx_dest_port;
        logic [3:0] rx_type;
        logic [3:0] rx_encryption;
        logic       crc_ok;
    } t_item;

    typedef struct packed {
        t_send_kind  send_kind;
        t_segment    seg;
        logic        deliver_rx;
        logic [3:0]  app_rx_encryption;
        logic        clear_app_tx;
        t_status     status;
        t_conn_state conn_state;
    } t_result;

endpackage

// File: rtl/core/tcf_cfg_regs.sv
// Configuration register file of the transport connection engine.
`timescale 1ns / 1ps

module tcf_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output tcf_pkg::t_cfg                    o_cfg
);

    tcf_pkg::t_cfg r_cfg;
    tcf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (tcf_pkg::t_cfg_index'(i_cfg_index))
                tcf_pkg::CFG_NET_ID:     n_cfg.net_id        = i_cfg_wdata[7:0];
                tcf_pkg::CFG_OWN_ADDR:   n_cfg.own_address   = i_cfg_wdata[7:0];
                tcf_pkg::CFG_TIMEOUT:    n_cfg.timeout_ticks = i_cfg_wdata[15:0];
                tcf_pkg::CFG_RESEND_LIM: n_cfg.resend_limit  = i_cfg_wdata[7:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.net_id        <= 8'd0;
            r_cfg.own_address   <= 8'd0;
            r_cfg.timeout_ticks <= tcf_pkg::TIMEOUT_RESET;
            r_cfg.resend_limit  <= tcf_pkg::RESEND_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/tcf_step.sv
// Next-state and result logic for one event of the connection engine.
`timescale 1ns / 1ps

module tcf_step (
    input  tcf_pkg::t_cfg    i_cfg,
    input  tcf_pkg::t_ctx    i_ctx,
    input  tcf_pkg::t_item   i_item,
    output tcf_pkg::t_ctx    o_ctx,
    output tcf_pkg::t_result o_result
);

    logic [15:0]       tc_dec;
    logic              q_en;
    logic              q_reload;
    tcf_pkg::t_segment q_seg;

    always_comb begin
        o_ctx    = i_ctx;
        o_result = '0;
        q_en     = 1'b0;
        q_reload = 1'b0;
        q_seg    = '0;
        tc_dec   = (i_ctx.timer_count != 16'd0) ? i_ctx.timer_count - 16'd1 : 16'd0;

        case (i_item.opcode)
            tcf_pkg::OP_TICK: begin
                o_ctx.timer_count = tc_dec;
                if (tc_dec == 16'd0 && i_ctx.state != tcf_pkg::ST_IDLE) begin
                    if (i_ctx.resends_left != 8'd0) begin
                        o_ctx.tx_busy      = 1'b1;
                        o_ctx.resends_left = i_ctx.resends_left - 8'd1;
                        o_ctx.timer_count  = i_cfg.timeout_ticks;
                        o_result.send_kind = tcf_pkg::SK_RESEND;
                        o_result.seg       = i_ctx.held;
                    end else begin
                        o_ctx.state   = tcf_pkg::ST_IDLE;
                        o_ctx.role    = tcf_pkg::ROLE_NONE;
                        o_ctx.tx_busy = 1'b0;
                    end
                end
            end
            tcf_pkg::OP_POLL: begin
                if (!i_ctx.tx_busy && i_item.app_tx_pending &&
                    i_ctx.state == tcf_pkg::ST_IDLE && i_ctx.role == tcf_pkg::ROLE_NONE) begin
                    o_ctx.state = tcf_pkg::ST_OPEN;
                    o_ctx.role  = tcf_pkg::ROLE_CLIENT;
                    q_en        = 1'b1;
                    q_reload    = 1'b1;
                    q_seg       = '{tcf_pkg::SEG_CONNECT, 4'd0, i_item.app_tx_port,
                                    i_item.app_tx_address, tcf_pkg::CTRL_SEG_LEN, 1'b0};
                end
                o_ctx.timer_count = i_cfg.timeout_ticks;
            end
            tcf_pkg::OP_RX: begin
                if (i_item.rx_address != i_cfg.own_address) begin
                    o_result.status = tcf_pkg::STS_ADDR;
                end else if (i_item.rx_net_id != i_cfg.net_id) begin
                    o_result.status = tcf_pkg::STS_NET_ID;
                end else if (i_ctx.state != tcf_pkg::ST_IDLE &&
                             i_item.rx_dest_port != i_item.app_tx_port) begin
                    o_result.status = tcf_pkg::STS_PORT;
                end else if (!i_item.crc_ok) begin
                    o_result.status = tcf_pkg::STS_CHECKSUM;
                end else begin
                    case (i_ctx.state)
                        tcf_pkg::ST_IDLE: begin
                            if (i_ctx.role == tcf_pkg::ROLE_NONE &&
                                i_item.rx_type == tcf_pkg::SEG_CONNECT) begin
                                if (!i_ctx.tx_busy) begin
                                    o_ctx.state = tcf_pkg::ST_OPEN;
                                    o_ctx.role  = tcf_pkg::ROLE_HOST;
                                    q_en        = 1'b1;
                                    q_reload    = 1'b1;
                                    q_seg       = '{tcf_pkg::SEG_ACCEPT, i_item.app_encryption,
                                                    i_item.app_tx_port, i_item.app_tx_address,
                                                    tcf_pkg::CTRL_SEG_LEN, 1'b0};
                                end
                                o_ctx.timer_count = i_cfg.timeout_ticks;
                            end
                        end
                        tcf_pkg::ST_OPEN: begin
                            if (i_ctx.role == tcf_pkg::ROLE_CLIENT &&
                                i_item.rx_type == tcf_pkg::SEG_ACCEPT) begin
                                if (!i_ctx.tx_busy) begin
                                    o_ctx.state                = tcf_pkg::ST_DATA;
                                    o_result.app_rx_encryption = i_item.rx_encryption;
                                    q_en     = 1'b1;
                                    q_reload = 1'b1;
                                    q_seg    = '{tcf_pkg::SEG_SEND, 4'd0, i_item.app_tx_port,
                                                 i_item.app_tx_address, i_item.app_tx_length,
                                                 1'b1};
                                end
                                o_ctx.timer_count = i_cfg.timeout_ticks;
                            end else if (i_ctx.role == tcf_pkg::ROLE_CLIENT &&
                                         i_item.rx_type == tcf_pkg::SEG_NACK) begin
                                o_ctx.state = tcf_pkg::ST_FAIL;
                                o_ctx.role  = tcf_pkg::ROLE_NONE;
                            end else if (i_ctx.role == tcf_pkg::ROLE_HOST &&
                                         i_item.rx_type == tcf_pkg::SEG_SEND) begin
                                if (!i_ctx.tx_busy) begin
                                    o_ctx.state         = tcf_pkg::ST_DATA;
                                    o_result.deliver_rx = 1'b1;
                                    q_en     = 1'b1;
                                    q_reload = 1'b1;
                                    q_seg    = '{tcf_pkg::SEG_ACK, 4'd0, i_item.app_tx_port,
                                                 i_item.app_tx_address, tcf_pkg::CTRL_SEG_LEN,
                                                 1'b0};
                                end
                                o_ctx.timer_count = i_cfg.timeout_ticks;
                            end
                        end
                        tcf_pkg::ST_DATA: begin
                            if (i_ctx.role == tcf_pkg::ROLE_CLIENT &&
                                (i_item.rx_type == tcf_pkg::SEG_ACK ||
                                 i_item.rx_type == tcf_pkg::SEG_NACK)) begin
                                if (!i_ctx.tx_busy) begin
                                    o_ctx.state           = tcf_pkg::ST_IDLE;
                                    o_ctx.role            = tcf_pkg::ROLE_NONE;
                                    o_result.clear_app_tx = (i_item.rx_type == tcf_pkg::SEG_ACK);
                                    q_en     = 1'b1;
                                    q_reload = (i_item.rx_type == tcf_pkg::SEG_ACK);
                                    q_seg    = '{tcf_pkg::SEG_CLOSE, 4'd0, i_item.app_tx_port,
                                                 i_item.app_tx_address, tcf_pkg::CTRL_SEG_LEN,
                                                 1'b0};
                                end
                            end else if (i_ctx.role == tcf_pkg::ROLE_HOST &&
                                         i_item.rx_type == tcf_pkg::SEG_CLOSE) begin
                                o_ctx.state = tcf_pkg::ST_IDLE;
                                o_ctx.role  = tcf_pkg::ROLE_NONE;
                            end
                        end
                        default: begin
                            o_ctx.state = i_ctx.state;
                        end
                    endcase
                end
            end
            tcf_pkg::OP_SENT: begin
                o_ctx.tx_busy = 1'b0;
            end
            default: begin
                o_ctx = i_ctx;
            end
        endcase

        if (q_en) begin
            o_ctx.held         = q_seg;
            o_ctx.tx_busy      = 1'b1;
            o_result.send_kind = tcf_pkg::SK_NEW;
            o_result.seg       = q_seg;
            if (q_reload) begin
                o_ctx.resends_left = i_cfg.resend_limit;
            end
        end

        o_result.conn_state = o_ctx.state;
    end

endmodule

// File: rtl/core/transport_connection_fsm.sv
// Top level of the transport connection engine with stream ports.
// Each input is held in the input register, and its result in the result register.
// Throughput: one event per cycle while results are accepted; the input register and the result
// register decouple the two streams, so an input is taken while a result waits if the input register is empty.
// Reset: synchronous, active low; clears the valid flags of both registers and the
// connection state, and loads the configuration registers and timer with their defaults.
`timescale 1ns / 1ps

module transport_connection_fsm (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // app_tx_pending, app_tx_port, app_tx_address, app_encryption, app_tx_length,
    // rx_address, rx_net_id, rx_dest_port, rx_type, rx_encryption, crc_ok
    input  logic [tcf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // opcode
    input  logic [1:0]                           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // send_type, send_encryption, send_port, send_address, send_length,
    // payload_from_app, deliver_rx, app_rx_encryption, clear_app_tx, status,
    // conn_state
    output logic [tcf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // send_kind
    output logic [1:0]                           m_axis_tuser,
    input  logic                                 i_cfg_wr_en,
    input  logic [tcf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tcf_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    tcf_pkg::t_cfg    cfg;
    tcf_pkg::t_item   in_item;
    tcf_pkg::t_ctx    n_ctx;
    tcf_pkg::t_result step_result;

    logic             r_in_valid;
    tcf_pkg::t_item   r_in_item;
    tcf_pkg::t_ctx    r_ctx;
    logic             r_out_valid;
    tcf_pkg::t_result r_out;
    logic             advance;

    tcf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    always_comb begin
        in_item.opcode         = tcf_pkg::t_opcode'(s_axis_tuser);
        in_item.app_tx_pending = s_axis_tdata[0];
        in_item.app_tx_port    = s_axis_tdata[8:1];
        in_item.app_tx_address = s_axis_tdata[16:9];
        in_item.app_encryption = s_axis_tdata[20:17];
        in_item.app_tx_length  = s_axis_tdata[28:21];
        in_item.rx_address     = s_axis_tdata[36:29];
        in_item.rx_net_id      = s_axis_tdata[44:37];
        in_item.rx_dest_port   = s_axis_tdata[52:45];
        in_item.rx_type        = s_axis_tdata[56:53];
        in_item.rx_encryption  = s_axis_tdata[60:57];
        in_item.crc_ok         = s_axis_tdata[61];
    end

    tcf_step u_step (
        .i_cfg    (cfg),
        .i_ctx    (r_ctx),
        .i_item   (r_in_item),
        .o_ctx    (n_ctx),
        .o_result (step_result)
    );

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_ctx.state       <= tcf_pkg::ST_IDLE;
            r_ctx.role        <= tcf_pkg::ROLE_NONE;
            r_ctx.tx_busy     <= 1'b0;
            r_ctx.resends_left <= 8'd0;
            r_ctx.timer_count <= tcf_pkg::TIMEOUT_RESET;
            r_ctx.held        <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_ctx       <= n_ctx;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= in_item;
        end
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.send_kind;
    assign m_axis_tdata  = {4'd0, r_out.conn_state, r_out.status, r_out.clear_app_tx,
                            r_out.app_rx_encryption, r_out.deliver_rx, r_out.seg.from_app,
                            r_out.seg.length, r_out.seg.address, r_out.seg.port,
                            r_out.seg.encryption, r_out.seg.seg_type};

endmodule

// File: rtl/core/tcf_checker.sv
// Port-level checks of the transport connection engine and their binding.
`timescale 1ns / 1ps

module tcf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tcf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic [1:0]                       m_axis_tuser
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result offered right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result changed.");

    a_no_send_zero_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == tcf_pkg::SK_NONE |-> m_axis_tdata[32:0] == '0)
        else $error("Segment fields set while nothing is sent.");

    a_filtered_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[41:39] != tcf_pkg::STS_OK |->
            m_axis_tuser == tcf_pkg::SK_NONE && !m_axis_tdata[33] && !m_axis_tdata[38])
        else $error("Rejected segment caused an action.");

    a_deliver_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[33] |->
            m_axis_tdata[43:42] == tcf_pkg::ST_DATA && m_axis_tuser == tcf_pkg::SK_NEW)
        else $error("Delivery without entering the data state with an ack.");

endmodule

bind transport_connection_fsm tcf_checker u_tcf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: dv/tcf_monitor.sv
// Checker that predicts every result of the transport connection engine and compares it.
`timescale 1ns / 1ps

module tcf_monitor
    import tcf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [1:0]             i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic [1:0]             i_m_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending
);

    t_cfg        cfg;
    t_conn_state link_state;
    t_role       link_role;
    logic        tx_busy;
    logic [7:0]  retries_left;
    logic [15:0] timer;
    t_segment    held;
    t_result     expected_replies[$];
    int          fail_count = 0;

    function automatic t_item unpack_item(input logic [IN_TDATA_W-1:0] d, input logic [1:0] u);
        t_item it;
        it.opcode         = t_opcode'(u);
        it.app_tx_pending = d[0];
        it.app_tx_port    = d[8:1];
        it.app_tx_address = d[16:9];
        it.app_encryption = d[20:17];
        it.app_tx_length  = d[28:21];
        it.rx_address     = d[36:29];
        it.rx_net_id      = d[44:37];
        it.rx_dest_port   = d[52:45];
        it.rx_type        = d[56:53];
        it.rx_encryption  = d[60:57];
        it.crc_ok         = d[61];
        return it;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Stores a new outgoing segment for later resends and reports it as sent now.
    task automatic queue_segment(inout t_result r, input logic [3:0] typ, input logic [3:0] enc,
                                 input logic [7:0] port, input logic [7:0] addr,
                                 input logic [7:0] len, input logic from_app,
                                 input logic refill);
        held.seg_type   = typ;
        held.encryption = enc;
        held.port       = port;
        held.address    = addr;
        held.length     = len;
        held.from_app   = from_app;
        tx_busy = 1'b1;
        if (refill) begin
            retries_left = cfg.resend_limit;
        end
        r.send_kind = SK_NEW;
        r.seg       = held;
    endtask

    task automatic predict_event(input t_item it, output t_result r);
        logic client;
        logic host;
        r = '0;
        client = (link_role == ROLE_CLIENT);
        host   = (link_role == ROLE_HOST);
        case (it.opcode)
            OP_TICK: begin
                if (timer != 16'd0) begin
                    timer = timer - 16'd1;
                end
                if (timer == 16'd0 && link_state != ST_IDLE) begin
                    if (retries_left != 8'd0) begin
                        tx_busy      = 1'b1;
                        retries_left = retries_left - 8'd1;
                        timer        = cfg.timeout_ticks;
                        r.send_kind  = SK_RESEND;
                        r.seg        = held;
                    end else begin
                        link_state = ST_IDLE;
                        link_role  = ROLE_NONE;
                        tx_busy    = 1'b0;
                    end
                end
            end
            OP_POLL: begin
                if (!tx_busy && it.app_tx_pending && link_state == ST_IDLE &&
                    link_role == ROLE_NONE) begin
                    link_state = ST_OPEN;
                    link_role  = ROLE_CLIENT;
                    queue_segment(r, SEG_CONNECT, 4'd0, it.app_tx_port, it.app_tx_address,
                                  CTRL_SEG_LEN, 1'b0, 1'b1);
                end
                timer = cfg.timeout_ticks;
            end
            OP_RX: begin
                if (it.rx_address != cfg.own_address) begin
                    r.status = STS_ADDR;
                end else if (it.rx_net_id != cfg.net_id) begin
                    r.status = STS_NET_ID;
                end else if (link_state != ST_IDLE && it.rx_dest_port != it.app_tx_port) begin
                    r.status = STS_PORT;
                end else if (!it.crc_ok) begin
                    r.status = STS_CHECKSUM;
                end else begin
                    case (link_state)
                        ST_IDLE: begin
                            if (link_role == ROLE_NONE && it.rx_type == SEG_CONNECT) begin
                                if (!tx_busy) begin
                                    link_state = ST_OPEN;
                                    link_role  = ROLE_HOST;
                                    queue_segment(r, SEG_ACCEPT, it.app_encryption,
                                                  it.app_tx_port, it.app_tx_address,
                                                  CTRL_SEG_LEN, 1'b0, 1'b1);
                                end
                                timer = cfg.timeout_ticks;
                            end
                        end
                        ST_OPEN: begin
                            if (client && it.rx_type == SEG_ACCEPT) begin
                                if (!tx_busy) begin
                                    link_state          = ST_DATA;
                                    r.app_rx_encryption = it.rx_encryption;
                                    queue_segment(r, SEG_SEND, 4'd0, it.app_tx_port,
                                                  it.app_tx_address, it.app_tx_length,
                                                  1'b1, 1'b1);
                                end
                                timer = cfg.timeout_ticks;
                            end else if (client && it.rx_type == SEG_NACK) begin
                                link_state = ST_FAIL;
                                link_role  = ROLE_NONE;
                            end else if (host && it.rx_type == SEG_SEND) begin
                                if (!tx_busy) begin
                                    link_state   = ST_DATA;
                                    r.deliver_rx = 1'b1;
                                    queue_segment(r, SEG_ACK, 4'd0, it.app_tx_port,
                                                  it.app_tx_address, CTRL_SEG_LEN,
                                                  1'b0, 1'b1);
                                end
                                timer = cfg.timeout_ticks;
                            end
                        end
                        ST_DATA: begin
                            if (client && it.rx_type == SEG_ACK) begin
                                if (!tx_busy) begin
                                    link_state     = ST_IDLE;
                                    link_role      = ROLE_NONE;
                                    r.clear_app_tx = 1'b1;
                                    queue_segment(r, SEG_CLOSE, 4'd0, it.app_tx_port,
                                                  it.app_tx_address, CTRL_SEG_LEN,
                                                  1'b0, 1'b1);
                                end
                            end else if (client && it.rx_type == SEG_NACK) begin
                                // The close after a nack keeps the remaining resends.
                                if (!tx_busy) begin
                                    link_state = ST_IDLE;
                                    link_role  = ROLE_NONE;
                                    queue_segment(r, SEG_CLOSE, 4'd0, it.app_tx_port,
                                                  it.app_tx_address, CTRL_SEG_LEN,
                                                  1'b0, 1'b0);
                                end
                            end else if (host && it.rx_type == SEG_CLOSE) begin
                                link_state = ST_IDLE;
                                link_role  = ROLE_NONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                tx_busy = 1'b0;
            end
        endcase
        r.conn_state = link_state;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg.net_id        = 8'd0;
            cfg.own_address   = 8'd0;
            cfg.timeout_ticks = TIMEOUT_RESET;
            cfg.resend_limit  = RESEND_RESET;
            link_state        = ST_IDLE;
            link_role         = ROLE_NONE;
            tx_busy           = 1'b0;
            retries_left      = 8'd0;
            timer             = TIMEOUT_RESET;
            held              = '0;
            expected_replies.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_NET_ID:     cfg.net_id        = i_cfg_wdata[7:0];
                    CFG_OWN_ADDR:   cfg.own_address   = i_cfg_wdata[7:0];
                    CFG_TIMEOUT:    cfg.timeout_ticks = i_cfg_wdata;
                    CFG_RESEND_LIM: cfg.resend_limit  = i_cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_event(unpack_item(i_s_tdata, i_s_tuser), want);
                expected_replies.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result with no prediction, expected none actual %0h/%0h",
                             $time, i_m_tuser, i_m_tdata);
                    fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    check_field("send_kind", want.send_kind, i_m_tuser);
                    check_field("send_type", want.seg.seg_type, i_m_tdata[3:0]);
                    check_field("send_encryption", want.seg.encryption, i_m_tdata[7:4]);
                    check_field("send_port", want.seg.port, i_m_tdata[15:8]);
                    check_field("send_address", want.seg.address, i_m_tdata[23:16]);
                    check_field("send_length", want.seg.length, i_m_tdata[31:24]);
                    check_field("payload_from_app", want.seg.from_app, i_m_tdata[32]);
                    check_field("deliver_rx", want.deliver_rx, i_m_tdata[33]);
                    check_field("app_rx_encryption", want.app_rx_encryption,
                                i_m_tdata[37:34]);
                    check_field("clear_app_tx", want.clear_app_tx, i_m_tdata[38]);
                    check_field("status", want.status, i_m_tdata[41:39]);
                    check_field("conn_state", want.conn_state, i_m_tdata[43:42]);
                end
            end
        end
        o_pending    <= expected_replies.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: dv/tb.sv
// Testbench top: clock, reset, stimulus and configuration of the connection engine.
`timescale 1ns / 1ps

module tb;
    import tcf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    int         fail_count;
    int         pending;
    int         items_sent = 0;
    int         cycles     = 0;
    logic       steady     = 1'b0;
    logic       stall_req  = 1'b0;
    logic [7:0] cfg_own    = 8'd0;
    logic [7:0] cfg_net    = 8'd0;
    logic [7:0] sess_port  = 8'd0;
    logic [7:0] sess_addr  = 8'd0;

    transport_connection_fsm u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    tcf_monitor u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[transport_connection_fsm] ERROR");
        $finish;
    end

    // The receiver mostly accepts, stalls briefly now and then, and rarely for long.
    initial begin : receiver
        int hold;
        int r;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                hold      = 400;
                stall_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (steady) begin
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    hold = (r < 97) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(input t_item it);
        return {2'b00, it.crc_ok, it.rx_encryption, it.rx_type, it.rx_dest_port,
                it.rx_net_id, it.rx_address, it.app_tx_length, it.app_encryption,
                it.app_tx_address, it.app_tx_port, it.app_tx_pending};
    endfunction

    function automatic t_item event_of(input t_opcode op);
        t_item it;
        it        = t_item'({$urandom, $urandom});
        it.opcode = op;
        return it;
    endfunction

    // A received header that passes every filter for the current session.
    function automatic t_item good_rx(input logic [3:0] typ);
        t_item it;
        it                = event_of(OP_RX);
        it.rx_address     = cfg_own;
        it.rx_net_id      = cfg_net;
        it.rx_dest_port   = sess_port;
        it.app_tx_port    = sess_port;
        it.app_tx_address = sess_addr;
        it.rx_type        = typ;
        it.crc_ok         = 1'b1;
        return it;
    endfunction

    function automatic t_item client_poll();
        t_item it;
        it                = event_of(OP_POLL);
        it.app_tx_pending = 1'b1;
        it.app_tx_port    = sess_port;
        it.app_tx_address = sess_addr;
        return it;
    endfunction

    task automatic push_item(input t_item it);
        int r;
        int n;
        s_axis_tdata  <= pack_item(it);
        s_axis_tuser  <= it.opcode;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        n = 0;
        if (!steady) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                n = $urandom_range(1, 3);
            end else if (r < 18) begin
                n = $urandom_range(8, 40);
            end
        end
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Session step: sometimes preceded by ticks, sometimes with a broken header.
    task automatic offer(input t_item it);
        int r;
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 3)) push_item(event_of(OP_TICK));
        end
        if (it.opcode == OP_RX && $urandom_range(0, 99) < 6) begin
            r = $urandom_range(0, 3);
            case (r)
                0: it.rx_address   = it.rx_address ^ 8'($urandom_range(1, 255));
                1: it.rx_net_id    = it.rx_net_id ^ 8'($urandom_range(1, 255));
                2: it.rx_dest_port = it.rx_dest_port ^ 8'($urandom_range(1, 255));
                default: it.crc_ok = 1'b0;
            endcase
        end
        push_item(it);
    endtask

    task automatic lower_layer_sent();
        if ($urandom_range(0, 9) != 0) begin
            push_item(event_of(OP_SENT));
        end
    endtask

    task automatic run_scenario();
        int r;
        r         = $urandom_range(0, 99);
        sess_port = 8'($urandom);
        sess_addr = 8'($urandom);
        if (r < 35) begin
            offer(client_poll());
            lower_layer_sent();
            offer(good_rx(($urandom_range(0, 7) == 0) ? SEG_NACK : SEG_ACCEPT));
            lower_layer_sent();
            offer(good_rx(($urandom_range(0, 5) == 0) ? SEG_NACK : SEG_ACK));
            lower_layer_sent();
        end else if (r < 70) begin
            offer(good_rx(SEG_CONNECT));
            lower_layer_sent();
            offer(good_rx(SEG_SEND));
            lower_layer_sent();
            offer(good_rx(SEG_CLOSE));
        end else if (r < 80) begin
            repeat ($urandom_range(1, 20)) push_item(event_of(OP_TICK));
        end else begin
            repeat ($urandom_range(1, 5)) begin
                if ($urandom_range(0, 1) == 0) begin
                    push_item(t_item'({$urandom, $urandom}));
                end else begin
                    offer(good_rx(4'($urandom)));
                end
            end
        end
    endtask

    task automatic program_regs(input logic [7:0] net, input logic [7:0] own,
                                input logic [15:0] tmo, input logic [7:0] lim);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_NET_ID;
        i_cfg_wdata <= {8'h00, net};
        @(posedge i_clk);
        i_cfg_index <= CFG_OWN_ADDR;
        i_cfg_wdata <= {8'h00, own};
        @(posedge i_clk);
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_wdata <= tmo;
        @(posedge i_clk);
        i_cfg_index <= CFG_RESEND_LIM;
        i_cfg_wdata <= {8'h00, lim};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_net = net;
        cfg_own = own;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_item it;
        int    target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A few events under the reset configuration.
        push_item(event_of(OP_TICK));
        it                = event_of(OP_POLL);
        it.app_tx_pending = 1'b0;
        push_item(it);
        drain();

        program_regs(8'hA5, 8'h5A, 16'd2, 8'd1);
        sess_port = 8'hFF;
        sess_addr = 8'h00;
        it                = event_of(OP_POLL);
        it.app_tx_pending = 1'b0;
        push_item(it);
        push_item(client_poll());
        push_item(event_of(OP_TICK));
        push_item(event_of(OP_TICK));
        push_item(event_of(OP_SENT));
        it            = good_rx(SEG_ACCEPT);
        it.rx_address = ~cfg_own;
        push_item(it);
        it           = good_rx(SEG_ACCEPT);
        it.rx_net_id = ~cfg_net;
        push_item(it);
        it              = good_rx(SEG_ACCEPT);
        it.rx_dest_port = ~sess_port;
        push_item(it);
        it        = good_rx(SEG_ACCEPT);
        it.crc_ok = 1'b0;
        push_item(it);
        push_item(good_rx(4'hF));
        it               = good_rx(SEG_ACCEPT);
        it.rx_encryption = 4'hF;
        it.app_tx_length = 8'hFF;
        push_item(it);
        push_item(good_rx(SEG_ACK));
        push_item(event_of(OP_SENT));
        push_item(good_rx(SEG_NACK));
        push_item(event_of(OP_SENT));
        // While idle the port is not checked.
        it                = good_rx(SEG_CONNECT);
        it.rx_dest_port   = 8'h00;
        it.app_encryption = 4'hF;
        push_item(it);
        push_item(event_of(OP_SENT));
        push_item(good_rx(SEG_SEND));
        push_item(event_of(OP_SENT));
        push_item(good_rx(SEG_CLOSE));
        it               = client_poll();
        it.app_tx_length = 8'h00;
        push_item(it);
        push_item(event_of(OP_SENT));
        push_item(good_rx(SEG_NACK));
        repeat (5) push_item(event_of(OP_TICK));

        for (int p = 0; p < 10; p++) begin
            drain();
            case (p)
                0: program_regs(8'h00, 8'h00, 16'd1, 8'd0);
                1: program_regs(8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
                2: program_regs(8'($urandom), 8'($urandom), 16'd0, 8'd2);
                3: program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 12)), 8'hFF);
                default: program_regs(8'($urandom), 8'($urandom),
                                      16'($urandom_range(1, 12)), 8'($urandom_range(0, 4)));
            endcase
            steady = (p == 5);
            if (p == 4 || p == 8) begin
                stall_req = 1'b1;
            end
            target = items_sent + 175;
            while (items_sent < target) run_scenario();
        end
        steady = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[transport_connection_fsm] OK");
        end else begin
            $display("[transport_connection_fsm] ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/tcf_pkg.sv
rtl/core/tcf_cfg_regs.sv
rtl/core/tcf_step.sv
rtl/core/transport_connection_fsm.sv
rtl/core/tcf_checker.sv
dv/tcf_monitor.sv
dv/tb.sv
